>>> sv/assert_macros.svh
// assertion macros used by the calendar date stepper top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

>>> sv/cds_pkg.sv
// types, codes and calendar helpers for the calendar date stepper
`default_nettype none

package cds_pkg;

   localparam int unsigned DAY_W   = 5;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned OP_W    = 3;
   localparam int unsigned STAT_W  = 2;

   // command codes
   localparam logic [OP_W-1:0] OP_LOAD      = 3'd0;
   localparam logic [OP_W-1:0] OP_DAY_INC   = 3'd1;
   localparam logic [OP_W-1:0] OP_DAY_DEC   = 3'd2;
   localparam logic [OP_W-1:0] OP_MONTH_INC = 3'd3;
   localparam logic [OP_W-1:0] OP_MONTH_DEC = 3'd4;
   localparam logic [OP_W-1:0] OP_YEAR_INC  = 3'd5;
   localparam logic [OP_W-1:0] OP_YEAR_DEC  = 3'd6;
   localparam logic [OP_W-1:0] OP_READ      = 3'd7;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_BADLOAD = 2'd1;
   localparam logic [STAT_W-1:0] ST_SAT     = 2'd2;

   // one command word as registered at the input
   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [DAY_W-1:0]   load_day;
      logic [MONTH_W-1:0] load_month;
      logic [YEAR_W-1:0]  load_year;
   } cmd_type;

   // current date plus year residues (year mod 100, century mod 4)
   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
      logic [6:0]         m100;
      logic [1:0]         c4;
   } date_type;

   // load check result handed to the step logic
   typedef struct packed {
      logic       ok;
      logic [6:0] m100;
      logic [1:0] c4;
   } load_chk_type;

   // leap year from the low year bits and the residues
   function automatic logic leap_of(logic [1:0] y_lo, logic [6:0] m100, logic [1:0] c4);
      return ((y_lo == 2'd0) && (m100 != 7'd0)) || ((m100 == 7'd0) && (c4 == 2'd0));
   endfunction

   // days in a month
   function automatic logic [DAY_W-1:0] month_len(logic [MONTH_W-1:0] m, logic leap);
      logic [DAY_W-1:0] len;
      if (m == 4'd2) begin
         len = leap ? 5'd29 : 5'd28;
      end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
         len = 5'd30;
      end else begin
         len = 5'd31;
      end
      return len;
   endfunction

endpackage

`default_nettype wire

>>> sv/cds_load_check.sv
// load command check: year residues and date validity of the load fields
`default_nettype none

module cds_load_check #(
   parameter int unsigned MAX_YEAR = 9999
) (
   input  var cds_pkg::cmd_type      cmd,
   output var cds_pkg::load_chk_type chk
);

   localparam logic [cds_pkg::YEAR_W-1:0] MAX_Y = cds_pkg::YEAR_W'(MAX_YEAR);

   logic [26:0]                 prod;
   logic [7:0]                  cent;
   logic [cds_pkg::YEAR_W-1:0]  cent_x100;
   logic [cds_pkg::YEAR_W-1:0]  rem;
   logic                        leap;

   // year / 100 by reciprocal: exact for all 14-bit years
   assign prod = {13'd0, cmd.load_year} * 27'd5243;
   assign cent = prod[26:19];

   // remainder: year - 100 * century
   assign cent_x100 = cds_pkg::YEAR_W'({cent, 6'd0}) + cds_pkg::YEAR_W'({cent, 5'd0})
                    + cds_pkg::YEAR_W'({cent, 2'd0});
   assign rem = cmd.load_year - cent_x100;

   assign leap = cds_pkg::leap_of(cmd.load_year[1:0], rem[6:0], cent[1:0]);

   // validity of month, year and day
   always_comb begin
      chk.m100 = rem[6:0];
      chk.c4   = cent[1:0];
      chk.ok   = (cmd.load_month >= 4'd1) && (cmd.load_month <= 4'd12)
              && (cmd.load_year <= MAX_Y) && (cmd.load_day != 5'd0)
              && (cmd.load_day <= cds_pkg::month_len(cmd.load_month, leap));
   end

endmodule

`default_nettype wire

>>> sv/cds_date_step.sv
// next-date logic for one command
`default_nettype none

module cds_date_step #(
   parameter int unsigned MAX_YEAR = 9999
) (
   input  var cds_pkg::cmd_type               cmd,
   input  var cds_pkg::load_chk_type          chk,
   input  var cds_pkg::date_type              cur,
   output var cds_pkg::date_type              nxt,
   output var logic                           leap,
   output var logic [cds_pkg::STAT_W-1:0]     status
);

   localparam logic [cds_pkg::YEAR_W-1:0] MAX_Y = cds_pkg::YEAR_W'(MAX_YEAR);

   logic [cds_pkg::YEAR_W-1:0]  year_inc;
   logic [cds_pkg::YEAR_W-1:0]  year_dec;
   logic [6:0]                  m100_inc;
   logic [6:0]                  m100_dec;
   logic [1:0]                  c4_inc;
   logic [1:0]                  c4_dec;
   logic                        leap_cur;
   logic                        leap_inc;
   logic                        leap_dec;
   logic [cds_pkg::MONTH_W-1:0] month_inc;
   logic [cds_pkg::MONTH_W-1:0] month_dec;
   logic                        at_max;
   logic                        at_zero;

   function automatic logic [cds_pkg::DAY_W-1:0] clamp(logic [cds_pkg::DAY_W-1:0] d,
                                                       logic [cds_pkg::DAY_W-1:0] len);
      return (d > len) ? len : d;
   endfunction

   // neighbor years and their residues
   assign year_inc = cur.year + 14'd1;
   assign year_dec = cur.year - 14'd1;
   assign m100_inc = (cur.m100 == 7'd99) ? 7'd0 : cur.m100 + 7'd1;
   assign c4_inc   = cur.c4 + {1'b0, cur.m100 == 7'd99};
   assign m100_dec = (cur.m100 == 7'd0) ? 7'd99 : cur.m100 - 7'd1;
   assign c4_dec   = cur.c4 - {1'b0, cur.m100 == 7'd0};

   assign leap_cur = cds_pkg::leap_of(cur.year[1:0], cur.m100, cur.c4);
   assign leap_inc = cds_pkg::leap_of(year_inc[1:0], m100_inc, c4_inc);
   assign leap_dec = cds_pkg::leap_of(year_dec[1:0], m100_dec, c4_dec);

   assign month_inc = cur.month + 4'd1;
   assign month_dec = cur.month - 4'd1;
   assign at_max    = (cur.year >= MAX_Y);
   assign at_zero   = (cur.year == 14'd0);

   // command decode
   always_comb begin
      nxt    = cur;
      status = cds_pkg::ST_OK;
      case (cmd.op)
         cds_pkg::OP_LOAD: begin
            if (chk.ok) begin
               nxt.day   = cmd.load_day;
               nxt.month = cmd.load_month;
               nxt.year  = cmd.load_year;
               nxt.m100  = chk.m100;
               nxt.c4    = chk.c4;
            end else begin
               status = cds_pkg::ST_BADLOAD;
            end
         end
         cds_pkg::OP_DAY_INC: begin
            if (cur.day < cds_pkg::month_len(cur.month, leap_cur)) begin
               nxt.day = cur.day + 5'd1;
            end else if (cur.month < 4'd12) begin
               nxt.day   = 5'd1;
               nxt.month = month_inc;
            end else if (!at_max) begin
               nxt.day   = 5'd1;
               nxt.month = 4'd1;
               nxt.year  = year_inc;
               nxt.m100  = m100_inc;
               nxt.c4    = c4_inc;
            end else begin
               status = cds_pkg::ST_SAT;
            end
         end
         cds_pkg::OP_DAY_DEC: begin
            if (cur.day > 5'd1) begin
               nxt.day = cur.day - 5'd1;
            end else if (cur.month > 4'd1) begin
               nxt.month = month_dec;
               nxt.day   = cds_pkg::month_len(month_dec, leap_cur);
            end else if (!at_zero) begin
               nxt.day   = 5'd31;
               nxt.month = 4'd12;
               nxt.year  = year_dec;
               nxt.m100  = m100_dec;
               nxt.c4    = c4_dec;
            end else begin
               status = cds_pkg::ST_SAT;
            end
         end
         cds_pkg::OP_MONTH_INC: begin
            if (cur.month < 4'd12) begin
               nxt.month = month_inc;
               nxt.day   = clamp(cur.day, cds_pkg::month_len(month_inc, leap_cur));
            end else if (!at_max) begin
               // january has 31 days, so the day stays
               nxt.month = 4'd1;
               nxt.year  = year_inc;
               nxt.m100  = m100_inc;
               nxt.c4    = c4_inc;
            end else begin
               status = cds_pkg::ST_SAT;
            end
         end
         cds_pkg::OP_MONTH_DEC: begin
            if (cur.month > 4'd1) begin
               nxt.month = month_dec;
               nxt.day   = clamp(cur.day, cds_pkg::month_len(month_dec, leap_cur));
            end else if (!at_zero) begin
               // december has 31 days, so the day stays
               nxt.month = 4'd12;
               nxt.year  = year_dec;
               nxt.m100  = m100_dec;
               nxt.c4    = c4_dec;
            end else begin
               status = cds_pkg::ST_SAT;
            end
         end
         cds_pkg::OP_YEAR_INC: begin
            if (!at_max) begin
               nxt.year = year_inc;
               nxt.m100 = m100_inc;
               nxt.c4   = c4_inc;
               nxt.day  = clamp(cur.day, cds_pkg::month_len(cur.month, leap_inc));
            end else begin
               status = cds_pkg::ST_SAT;
            end
         end
         cds_pkg::OP_YEAR_DEC: begin
            if (!at_zero) begin
               nxt.year = year_dec;
               nxt.m100 = m100_dec;
               nxt.c4   = c4_dec;
               nxt.day  = clamp(cur.day, cds_pkg::month_len(cur.month, leap_dec));
            end else begin
               status = cds_pkg::ST_SAT;
            end
         end
         cds_pkg::OP_READ: begin
            nxt = cur;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

   // leap flag of the resulting year
   assign leap = cds_pkg::leap_of(nxt.year[1:0], nxt.m100, nxt.c4);

endmodule

`default_nettype wire

>>> sv/calendar_date_stepper.sv
// top level of the calendar date stepper: input register, date state, result register
`default_nettype none
`include "assert_macros.svh"

// Calendar date stepper. Holds a Gregorian date (reset: 1 January 2000) and
// takes one command word per clock on the req_ channel: load, step day, month
// or year up or down, or read. Every command returns one rsp_ word with the date
// after the command, its leap flag and a status (0 ok, 1 load rejected, 2 year
// limit reached, date unchanged). A command is captured in the input register,
// then applied to the date register once the output register is free or being read,
// and its result word is written to the output register at the same time; a new
// command is taken every cycle while rsp_ready stays high. The year is kept
// with its mod-100 and century-mod-4 residues so leap years need no divider; only
// a load computes the residues, through one small reciprocal multiply.

module calendar_date_stepper #(
   parameter int unsigned MAX_YEAR = 9999
) (
   input  var logic                          clock,
   input  var logic                          reset,
   input  var logic                          req_valid,
   output var logic                          req_ready,
   input  var logic [cds_pkg::OP_W-1:0]      req_op,
   input  var logic [cds_pkg::DAY_W-1:0]     req_load_day,
   input  var logic [cds_pkg::MONTH_W-1:0]   req_load_month,
   input  var logic [cds_pkg::YEAR_W-1:0]    req_load_year,
   output var logic                          rsp_valid,
   input  var logic                          rsp_ready,
   output var logic [cds_pkg::DAY_W-1:0]     rsp_day,
   output var logic [cds_pkg::MONTH_W-1:0]   rsp_month,
   output var logic [cds_pkg::YEAR_W-1:0]    rsp_year,
   output var logic                          rsp_leap,
   output var logic [cds_pkg::STAT_W-1:0]    rsp_status
);

   localparam logic [cds_pkg::YEAR_W-1:0] MAX_Y = cds_pkg::YEAR_W'(MAX_YEAR);

   cds_pkg::cmd_type              cmd_ff;
   logic                          cmd_valid_ff;
   cds_pkg::date_type             date_ff;
   cds_pkg::date_type             date_in;
   cds_pkg::load_chk_type         chk;
   logic                          leap_in;
   logic [cds_pkg::STAT_W-1:0]    status_in;
   logic                          rsp_valid_ff;
   logic [cds_pkg::DAY_W-1:0]     rsp_day_ff;
   logic [cds_pkg::MONTH_W-1:0]   rsp_month_ff;
   logic [cds_pkg::YEAR_W-1:0]    rsp_year_ff;
   logic                          rsp_leap_ff;
   logic [cds_pkg::STAT_W-1:0]    rsp_status_ff;
   logic                          advance;
   logic                          req_take;
   logic                          date_legal;
   logic                          day_fits;

   // pipeline control
   assign advance   = cmd_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !cmd_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else if (req_take) begin
         cmd_valid_ff <= 1'b1;
      end else if (advance) begin
         cmd_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff.op         <= req_op;
         cmd_ff.load_day   <= req_load_day;
         cmd_ff.load_month <= req_load_month;
         cmd_ff.load_year  <= req_load_year;
      end
   end

   cds_load_check #(.MAX_YEAR(MAX_YEAR)) u_load_check (
      .cmd (cmd_ff),
      .chk (chk)
   );

   cds_date_step #(.MAX_YEAR(MAX_YEAR)) u_date_step (
      .cmd    (cmd_ff),
      .chk    (chk),
      .cur    (date_ff),
      .nxt    (date_in),
      .leap   (leap_in),
      .status (status_in)
   );

   // date state, 2000 has year mod 100 = 0 and century mod 4 = 0
   always_ff @(posedge clock) begin
      if (reset) begin
         date_ff.day   <= 5'd1;
         date_ff.month <= 4'd1;
         date_ff.year  <= 14'd2000;
         date_ff.m100  <= 7'd0;
         date_ff.c4    <= 2'd0;
      end else if (advance) begin
         date_ff <= date_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_day_ff    <= date_in.day;
         rsp_month_ff  <= date_in.month;
         rsp_year_ff   <= date_in.year;
         rsp_leap_ff   <= leap_in;
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_day    = rsp_day_ff;
   assign rsp_month  = rsp_month_ff;
   assign rsp_year   = rsp_year_ff;
   assign rsp_leap   = rsp_leap_ff;
   assign rsp_status = rsp_status_ff;

   // calendar bounds of the held date
   assign date_legal = (date_ff.month >= 4'd1) && (date_ff.month <= 4'd12)
                    && (date_ff.day >= 5'd1) && (date_ff.year <= MAX_Y)
                    && (date_ff.m100 < 7'd100);
   assign day_fits   = date_ff.day <= cds_pkg::month_len(date_ff.month,
                          cds_pkg::leap_of(date_ff.year[1:0], date_ff.m100, date_ff.c4));

   // date stays within calendar bounds
   `ASSERT_CLK(a_date_legal, clock, reset, date_legal)
   // day never beyond the month length
   `ASSERT_CLK(a_day_fits, clock, reset, day_fits)
   // date only changes when a word is processed
   `ASSERT_CLK(a_date_hold, clock, reset, !advance |=> $stable(date_ff))
   // a rejected or saturated word leaves the date alone
   `ASSERT_CLK(a_err_no_change, clock, reset, (advance && (status_in != cds_pkg::ST_OK)) |=> $stable(date_ff))
   // the result word carries the updated year
   `ASSERT_CLK(a_rsp_year, clock, reset, advance |=> (rsp_year == date_ff.year))

endmodule

`default_nettype wire
